// ===== design/rlss_pkg.sv =====
package rlss_pkg;

    localparam int COLOUR_W = 24;
    localparam int BITS_PER_LED = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int DUR_REG_W = 15;
    localparam int COUNT_REG_W = 9;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_LOW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_LEN = 3'd4;

    localparam logic [DUR_REG_W-1:0]   ZERO_HIGH_RST = 15'd14;
    localparam logic [DUR_REG_W-1:0]   ZERO_LOW_RST  = 15'd34;
    localparam logic [DUR_REG_W-1:0]   ONE_HIGH_RST  = 15'd32;
    localparam logic [DUR_REG_W-1:0]   ONE_LOW_RST   = 15'd18;
    localparam logic [COUNT_REG_W-1:0] STRIP_LEN_RST = 9'd1;

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_READ = 2'd1,
        KIND_FILL = 2'd2,
        KIND_TICK = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_EXEC,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic exec;
        logic sweep_clr;
        logic sweep_wr;
        logic clearing;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  sweep_done;
        logic  out_free;
    } status_t;

endpackage

// ===== design/rgb_led_strip_serializer_unit.sv =====
// Channel   Direction  Handshake               Payload
// s_        in         s_tvalid / s_tready     s_tdata, s_tuser (kind)
// m_        out        m_tvalid / m_tready     m_tdata
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Set, read and tick items pass through capture, store read and execute steps.
// The store read step comes from the registered read of the colour store.
// A fill item writes the store once per LED, for min(strip length, MAX_LEDS) LEDs.
// After reset a clearing pass zeroes all MAX_LEDS store entries; no item
// is accepted meanwhile. Configuration writes are taken in any cycle.
// A result held on m_ stalls the execute step; no new item is taken until it completes.
module rgb_led_strip_serializer_unit #(
    parameter int MAX_LEDS   = 256,
    parameter int TICK_WIDTH = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlss_pkg::S_TDATA_W-1:0]      s_tdata,   // led_index, red, green, blue
    input  logic [1:0]                          s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // line_level, read_red, read_green, read_blue, busy_res, index_error, zero pad
    output logic [rlss_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rlss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rlss_pkg::cmd_t    cmd;
    rlss_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rlss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rlss_dpath #(
        .MAX_LEDS   (MAX_LEDS),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/rlss_ram.sv =====
module rlss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [AW-1:0]          raddr,
    output logic [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rlss_ctrl.sv =====
module rlss_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rlss_pkg::status_t status,
    output rlss_pkg::cmd_t    cmd
);

    rlss_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlss_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rlss_pkg::ST_CLEAR: begin
                if (status.sweep_done) begin
                    state_next = rlss_pkg::ST_IDLE;
                end
            end
            rlss_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rlss_pkg::ST_FETCH;
                end
            end
            rlss_pkg::ST_FETCH: begin
                state_next = rlss_pkg::ST_EXEC;
            end
            rlss_pkg::ST_EXEC: begin
                if (status.kind == rlss_pkg::KIND_FILL) begin
                    state_next = rlss_pkg::ST_FILL;
                end else if (status.out_free) begin
                    state_next = rlss_pkg::ST_IDLE;
                end
            end
            rlss_pkg::ST_FILL: begin
                if (status.sweep_done && status.out_free) begin
                    state_next = rlss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rlss_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            rlss_pkg::ST_CLEAR: begin
                cmd.clearing  = 1'b1;
                cmd.sweep_wr  = !status.sweep_done;
                cmd.sweep_clr = status.sweep_done;
            end
            rlss_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            rlss_pkg::ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            rlss_pkg::ST_EXEC: begin
                if (status.kind == rlss_pkg::KIND_FILL) begin
                    cmd.sweep_clr = 1'b1;
                end else begin
                    cmd.exec = status.out_free;
                end
            end
            rlss_pkg::ST_FILL: begin
                cmd.sweep_wr = !status.sweep_done;
                cmd.exec     = status.sweep_done && status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/rlss_dpath.sv =====
module rlss_dpath #(
    parameter int MAX_LEDS   = 256,
    parameter int TICK_WIDTH = 15
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rlss_pkg::cmd_t                        cmd,
    output rlss_pkg::status_t                     status,
    input  logic [rlss_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic [1:0]                            s_tuser,
    input  logic                                  cfg_valid,
    input  logic [rlss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rlss_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rlss_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CW = AW + 1;
    localparam int TW = TICK_WIDTH;

    logic [rlss_pkg::DUR_REG_W-1:0]   zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [rlss_pkg::COUNT_REG_W-1:0] strip_len_reg;

    rlss_pkg::kind_t                  kind_reg;
    logic [7:0]                       idx_reg;
    logic [rlss_pkg::COLOUR_W-1:0]    word_reg;

    logic [CW-1:0]                    sweep_reg;
    logic                             sending_reg, sending_next;
    logic                             pending_reg, pending_next;
    logic [AW-1:0]                    ptr_reg, ptr_next;
    logic [4:0]                       bp_reg, bp_next;
    logic                             phase_reg, phase_next;
    logic [TW-1:0]                    tc_reg, tc_next;
    logic                             m_valid_reg;
    logic [rlss_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic [CW-1:0]                    count;
    logic [CW-1:0]                    sweep_limit;
    logic                             idx_ok;
    logic                             s1;
    logic                             out_free;
    logic                             set_wr;
    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr, ram_raddr;
    logic [rlss_pkg::COLOUR_W-1:0]    ram_wdata, rdata;

    function automatic logic [TW-1:0] dur(input logic [rlss_pkg::DUR_REG_W-1:0] r);
        logic [TW-1:0] d;
        d = TW'(r);
        return (d == '0) ? TW'(1) : d;
    endfunction

    assign count = (32'(strip_len_reg) >= MAX_LEDS) ? CW'(MAX_LEDS) : CW'(strip_len_reg);
    assign idx_ok = (32'(idx_reg) < 32'(count));
    assign s1 = sending_reg && (32'(ptr_reg) < 32'(count));
    assign out_free = !m_valid_reg || m_tready;
    assign sweep_limit = cmd.clearing ? CW'(MAX_LEDS) : count;

    assign status.kind       = kind_reg;
    assign status.sweep_done = (sweep_reg >= sweep_limit);
    assign status.out_free   = out_free;

    assign set_wr    = cmd.exec && (kind_reg == rlss_pkg::KIND_SET) && idx_ok
                       && (rdata != word_reg);
    assign ram_we    = cmd.sweep_wr || set_wr;
    assign ram_waddr = cmd.sweep_wr ? sweep_reg[AW-1:0] : AW'(idx_reg);
    assign ram_wdata = cmd.clearing ? '0 : word_reg;
    assign ram_raddr = (kind_reg == rlss_pkg::KIND_TICK) ? (s1 ? ptr_reg : '0) : AW'(idx_reg);

    rlss_ram #(
        .WIDTH (rlss_pkg::COLOUR_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.fetch),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_high_reg <= rlss_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= rlss_pkg::ZERO_LOW_RST;
            one_high_reg  <= rlss_pkg::ONE_HIGH_RST;
            one_low_reg   <= rlss_pkg::ONE_LOW_RST;
            strip_len_reg <= rlss_pkg::STRIP_LEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rlss_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data;
                rlss_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                rlss_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data;
                rlss_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data;
                rlss_pkg::REG_STRIP_LEN: strip_len_reg <= cfg_data[rlss_pkg::COUNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= rlss_pkg::kind_t'(s_tuser);
            idx_reg  <= s_tdata[7:0];
            word_reg <= {s_tdata[23:16], s_tdata[15:8], s_tdata[31:24]};
        end
        if (cmd.exec) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg   <= '0;
            sending_reg <= 1'b0;
            pending_reg <= 1'b0;
            ptr_reg     <= '0;
            bp_reg      <= '0;
            phase_reg   <= 1'b0;
            tc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.sweep_clr) begin
                sweep_reg <= '0;
            end else if (cmd.sweep_wr) begin
                sweep_reg <= sweep_reg + CW'(1);
            end
            sending_reg <= sending_next;
            pending_reg <= pending_next;
            ptr_reg     <= ptr_next;
            bp_reg      <= bp_next;
            phase_reg   <= phase_next;
            tc_reg      <= tc_next;
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        logic          level, busy, err, start, active, bit_v, tdone;
        logic [7:0]    rr, rg, rb;
        logic [AW-1:0] ptr_e;
        logic [4:0]    bp_e;
        logic          ph_e;
        logic [TW-1:0] tc_e, len, tc1;
        logic [CW-1:0] ptr_inc;

        sending_next = sending_reg;
        pending_next = pending_reg;
        ptr_next     = ptr_reg;
        bp_next      = bp_reg;
        phase_next   = phase_reg;
        tc_next      = tc_reg;
        level        = sending_reg && !phase_reg;
        busy         = sending_reg;
        err          = 1'b0;
        rr           = '0;
        rg           = '0;
        rb           = '0;
        start        = !s1 && pending_reg;
        active       = s1 || (start && (count != '0));
        ptr_e        = s1 ? ptr_reg : '0;
        bp_e         = s1 ? bp_reg : '0;
        ph_e         = s1 ? phase_reg : 1'b0;
        tc_e         = s1 ? tc_reg : '0;
        bit_v        = rdata[5'd23 - bp_e];
        if (!ph_e) begin
            len = bit_v ? dur(one_high_reg) : dur(zero_high_reg);
        end else begin
            len = bit_v ? dur(one_low_reg) : dur(zero_low_reg);
        end
        tc1     = tc_e + TW'(1);
        tdone   = (tc1 >= len) || (tc1 == '0);
        ptr_inc = {1'b0, ptr_e} + CW'(1);

        if (cmd.exec) begin
            unique case (kind_reg)
                rlss_pkg::KIND_SET: begin
                    err = !idx_ok;
                    if (set_wr) begin
                        pending_next = 1'b1;
                    end
                end
                rlss_pkg::KIND_READ: begin
                    err = !idx_ok;
                    if (idx_ok) begin
                        rg = rdata[23:16];
                        rr = rdata[15:8];
                        rb = rdata[7:0];
                    end
                end
                rlss_pkg::KIND_FILL: begin
                    pending_next = 1'b1;
                end
                rlss_pkg::KIND_TICK: begin
                    if (start) begin
                        pending_next = 1'b0;
                    end
                    if (!active) begin
                        sending_next = 1'b0;
                        level        = 1'b0;
                        busy         = 1'b0;
                    end else begin
                        busy         = 1'b1;
                        level        = !ph_e;
                        sending_next = 1'b1;
                        ptr_next     = ptr_e;
                        bp_next      = bp_e;
                        phase_next   = ph_e;
                        tc_next      = tc1;
                        if (tdone) begin
                            tc_next = '0;
                            if (!ph_e) begin
                                phase_next = 1'b1;
                            end else begin
                                phase_next = 1'b0;
                                if (bp_e == 5'(rlss_pkg::BITS_PER_LED - 1)) begin
                                    bp_next = '0;
                                    if (ptr_inc >= count) begin
                                        sending_next = 1'b0;
                                        ptr_next     = '0;
                                    end else begin
                                        ptr_next = ptr_inc[AW-1:0];
                                    end
                                end else begin
                                    bp_next = bp_e + 5'd1;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        m_data_next = {5'd0, err, busy, rb, rg, rr, level};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== design/rlss_checker.sv =====
module rlss_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rlss_pkg::M_TDATA_W-1:0]   m_tdata
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready shown straight after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    a_err_no_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26] |-> m_tdata[24:1] == 24'd0)
        else $error("index error item carries colour");

    a_level_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[25])
        else $error("line high while not sending");

endmodule

bind rgb_led_strip_serializer_unit rlss_checker u_rlss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
module tb;

    localparam int LED_SLOTS = 256;
    localparam int IDLE_TAIL = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int CFG_W = rlss_pkg::CFG_DATA_W;
    localparam logic [rlss_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] led_index;
    } item_t;

    typedef struct packed {
        logic [4:0] pad;
        logic       index_error;
        logic       busy;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       level;
    } result_t;

    class strip_scoreboard;
        logic [rlss_pkg::COLOUR_W-1:0]    colours [LED_SLOTS];
        bit                               sending;
        bit                               refresh_due;
        int unsigned                      led_ptr;
        int unsigned                      bit_ptr;
        bit                               low_part;
        logic [rlss_pkg::DUR_REG_W-1:0]   tick_cnt;
        logic [rlss_pkg::DUR_REG_W-1:0]   zero_high;
        logic [rlss_pkg::DUR_REG_W-1:0]   zero_low;
        logic [rlss_pkg::DUR_REG_W-1:0]   one_high;
        logic [rlss_pkg::DUR_REG_W-1:0]   one_low;
        logic [rlss_pkg::COUNT_REG_W-1:0] strip_len;
        result_t                          due_results [$];
        int                               fail_count;

        function new();
            foreach (colours[i]) colours[i] = '0;
            sending = 0;
            refresh_due = 0;
            led_ptr = 0;
            bit_ptr = 0;
            low_part = 0;
            tick_cnt = '0;
            zero_high = rlss_pkg::ZERO_HIGH_RST;
            zero_low = rlss_pkg::ZERO_LOW_RST;
            one_high = rlss_pkg::ONE_HIGH_RST;
            one_low = rlss_pkg::ONE_LOW_RST;
            strip_len = rlss_pkg::STRIP_LEN_RST;
            fail_count = 0;
        endfunction

        function int leds_in_use();
            return (strip_len < LED_SLOTS) ? int'(strip_len) : LED_SLOTS;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void write_reg(logic [rlss_pkg::CFG_INDEX_W-1:0] index,
                                logic [rlss_pkg::CFG_DATA_W-1:0] value);
            case (index)
                rlss_pkg::REG_ZERO_HIGH: zero_high = value;
                rlss_pkg::REG_ZERO_LOW:  zero_low = value;
                rlss_pkg::REG_ONE_HIGH:  one_high = value;
                rlss_pkg::REG_ONE_LOW:   one_low = value;
                rlss_pkg::REG_STRIP_LEN: strip_len = value[rlss_pkg::COUNT_REG_W-1:0];
                default: ;
            endcase
        endfunction

        function void advance_line(output logic level, output logic busy);
            int   n;
            int   len;
            logic bit_val;
            logic [rlss_pkg::DUR_REG_W-1:0] dur;
            n = leds_in_use();
            if (sending && led_ptr >= n) sending = 0;
            if (!sending && refresh_due) begin
                refresh_due = 0;
                if (n > 0) begin
                    sending = 1;
                    led_ptr = 0;
                    bit_ptr = 0;
                    low_part = 0;
                    tick_cnt = '0;
                end
            end
            if (!sending) begin
                level = 0;
                busy = 0;
                return;
            end
            busy = 1;
            level = !low_part;
            bit_val = colours[led_ptr][23 - bit_ptr];
            if (low_part) dur = bit_val ? one_low : zero_low;
            else dur = bit_val ? one_high : zero_high;
            len = (dur == 0) ? 1 : int'(dur);
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= len || tick_cnt == 0) begin
                tick_cnt = '0;
                if (!low_part) begin
                    low_part = 1;
                end else begin
                    low_part = 0;
                    bit_ptr++;
                    if (bit_ptr >= rlss_pkg::BITS_PER_LED) begin
                        bit_ptr = 0;
                        led_ptr++;
                        if (led_ptr >= n) begin
                            sending = 0;
                            led_ptr = 0;
                        end
                    end
                end
            end
        endfunction

        function void note_item(rlss_pkg::kind_t kind, logic [rlss_pkg::S_TDATA_W-1:0] data);
            item_t                         it;
            result_t                       res;
            logic [rlss_pkg::COLOUR_W-1:0] word;
            int                            n;
            it = data;
            word = {it.green, it.red, it.blue};
            n = leds_in_use();
            res = '0;
            if (kind == rlss_pkg::KIND_TICK) begin
                advance_line(res.level, res.busy);
            end else begin
                case (kind)
                    rlss_pkg::KIND_SET: begin
                        if (it.led_index < n) begin
                            if (colours[it.led_index] != word) begin
                                colours[it.led_index] = word;
                                refresh_due = 1;
                            end
                        end else begin
                            res.index_error = 1;
                        end
                    end
                    rlss_pkg::KIND_READ: begin
                        if (it.led_index < n) begin
                            {res.green, res.red, res.blue} = colours[it.led_index];
                        end else begin
                            res.index_error = 1;
                        end
                    end
                    default: begin
                        for (int i = 0; i < n; i++) colours[i] = word;
                        refresh_due = 1;
                    end
                endcase
                res.level = sending && !low_part;
                res.busy = sending;
            end
            due_results.push_back(res);
        endfunction

        function void check_result(logic [rlss_pkg::M_TDATA_W-1:0] data);
            result_t got;
            result_t want;
            got = data;
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result %08h with nothing outstanding", data);
                return;
            end
            want = due_results.pop_front();
            if (got.level !== want.level || got.red !== want.red
                    || got.green !== want.green || got.blue !== want.blue
                    || got.busy !== want.busy || got.index_error !== want.index_error) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"mismatch: expected lvl %0d rgb %02h %02h %02h busy %0d err %0d,",
                              " got lvl %0d rgb %02h %02h %02h busy %0d err %0d"},
                             want.level, want.red, want.green, want.blue, want.busy,
                             want.index_error, got.level, got.red, got.green, got.blue,
                             got.busy, got.index_error);
            end
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rlss_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [1:0]                       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rlss_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [rlss_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rlss_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    strip_scoreboard sb = new();
    int burst_left = 0;
    bit hold_request = 0;

    rgb_led_strip_serializer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(rlss_pkg::kind_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    initial begin
        int cyc;
        int hold_left;
        int ready_mode;
        cyc = 0;
        hold_left = 0;
        ready_mode = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            cyc++;
            if (cyc % 50 == 0) ready_mode = $urandom_range(0, 2);
        end
    end

    initial begin
        #7200000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic offer(rlss_pkg::kind_t kind, logic [7:0] idx, logic [7:0] red,
                         logic [7:0] green, logic [7:0] blue);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {blue, green, red, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (IDLE_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(logic [rlss_pkg::CFG_INDEX_W-1:0] index,
                             logic [rlss_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_items(int n);
        int                            pick;
        int                            span;
        rlss_pkg::kind_t               kind;
        logic [7:0]                    idx;
        logic [31:0]                   rnd;
        logic [rlss_pkg::COLOUR_W-1:0] c;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) kind = rlss_pkg::KIND_TICK;
            else if (pick < 73) kind = rlss_pkg::KIND_SET;
            else if (pick < 93) kind = rlss_pkg::KIND_READ;
            else kind = rlss_pkg::KIND_FILL;
            span = sb.leds_in_use();
            if (span > 0 && $urandom_range(0, 9) != 0) idx = 8'($urandom_range(0, span - 1));
            else idx = 8'($urandom_range(0, 255));
            rnd = $urandom;
            c = rnd[23:0];
            if (kind == rlss_pkg::KIND_SET && $urandom_range(0, 4) == 0) c = sb.colours[idx];
            offer(kind, idx, c[15:8], c[23:16], c[7:0]);
        end
    endtask

    task automatic run_phase(int zh, int zl, int oh, int ol, int cnt, int n);
        settle();
        write_reg(rlss_pkg::REG_ZERO_HIGH, CFG_W'(zh));
        write_reg(rlss_pkg::REG_ZERO_LOW, CFG_W'(zl));
        write_reg(rlss_pkg::REG_ONE_HIGH, CFG_W'(oh));
        write_reg(rlss_pkg::REG_ONE_LOW, CFG_W'(ol));
        write_reg(rlss_pkg::REG_STRIP_LEN, CFG_W'(cnt));
        random_items(n);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        offer(rlss_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        offer(rlss_pkg::KIND_SET, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        offer(rlss_pkg::KIND_SET, 8'd1, 8'h11, 8'h22, 8'h33);
        offer(rlss_pkg::KIND_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        offer(rlss_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        offer(rlss_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_TICK, 8'd255, 8'hFF, 8'hFF, 8'hFF);
        offer(rlss_pkg::KIND_SET, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_FILL, 8'd0, 8'h12, 8'h34, 8'h56);
        offer(rlss_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_FILL, 8'd255, 8'hFF, 8'h00, 8'hFF);
        offer(rlss_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_FILL, 8'd0, 8'h00, 8'hFF, 8'h00);
        offer(rlss_pkg::KIND_READ, 8'd0, 8'h00, 8'h00, 8'h00);
        offer(rlss_pkg::KIND_TICK, 8'd0, 8'h00, 8'h00, 8'h00);

        run_phase(1, 1, 1, 1, 1, 110);
        run_phase(0, 0, 0, 0, 2, 45);
        settle();
        hold_request = 1;
        random_items(45);
        run_phase(2, 1, 1, 2, 3, 90);
        run_phase(1, 1, 1, 1, 0, 40);
        run_phase(32767, 32767, 32767, 32767, 256, 40);
        run_phase(1, 2, 1, 2, 511, 40);
        run_phase(3, 1, 1, 3, 8, 60);
        settle();
        write_reg(REG_UNUSED, 15'h7FFF);
        run_phase(1, 1, 2, 2, 2, 80);

        settle();
        repeat (20) @(posedge aclk);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
